/* rtl/core/tlpt_pkg.sv */
// shared types, constants and codes of the two-level page table engine
package tlpt_pkg;

  // fixed geometry of the directory and of one second-level table
  localparam int DIR_COUNT         = 1024;
  localparam int DIR_IDX_W         = 10;
  localparam int ENTRIES_PER_TABLE = 1024;
  localparam int TBL_IDX_W         = 10;
  // one sweep counter serves the directory clear and the table zeroing
  localparam int SWEEP_W           = 10;
  localparam int DEF_TABLE_SLOTS   = 8;

  // stream payload widths
  localparam int IN_DATA_W  = 80;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_USER_W = 1;

  // request codes
  localparam logic [1:0] OP_MAP   = 2'd0;
  localparam logic [1:0] OP_UNMAP = 2'd1;
  localparam logic [1:0] OP_XLATE = 2'd2;

  // leaf entry flag bits
  localparam logic [11:0] FLAG_PRESENT = 12'h001;

  // directory entry flag bits (slot number sits above them)
  localparam logic [2:0] DIR_PRESENT  = 3'b001;
  localparam logic [2:0] DIR_WRITABLE = 3'b010;
  localparam logic [2:0] DIR_USER     = 3'b100;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECIDE,
    ST_ZERO,
    ST_LEAF_WR,
    ST_LEAF_CHK,
    ST_DONE
  } state_t;

  // how the result registers are updated
  typedef enum logic [1:0] {
    RES_HOLD,
    RES_FAIL,
    RES_PASS,
    RES_LEAF
  } res_kind_t;

  typedef struct packed {
    logic      load_req;
    logic      dir_rd;
    logic      dir_clear_wr;
    logic      dir_alloc_wr;
    logic      dir_merge_wr;
    logic      slot_ld;
    logic      pool_zero_wr;
    logic      pool_leaf_wr;
    logic      cnt_clr;
    logic      cnt_inc;
    res_kind_t res_kind;
    logic      load_out;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       dir_present;
    logic       pool_full;
    logic       cnt_last;
    logic       out_free;
  } status_t;

endpackage

/* rtl/core/two_level_page_table_engine.sv */
// top level of the two-level page table engine
//
// channel   dir   fields
// s_*       in    tuser: operation [1:0]; tdata: virt_addr, phys_addr, entry_flags
// m_*       out   tuser: ok [0]; tdata: translated [31:0]
//
// a request passes through directory read, decide, leaf access and output load in turn
// a request that fails in the decide step skips the leaf access
// a map that allocates a table first zeroes all ENTRIES_PER_TABLE (1024) entries of that table
// after reset all 1024 directory entries are cleared with s_tready low
// one request at a time; a result waits in the output register while m_tready is low
// and the next request is accepted meanwhile, holding only if its own result must wait
module two_level_page_table_engine
  import tlpt_pkg::*;
#(
  parameter int TABLE_SLOTS = DEF_TABLE_SLOTS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // virt_addr [31:0], phys_addr [63:32], entry_flags [75:64], zero [79:76]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // operation [1:0]
  input  logic [IN_USER_W-1:0]  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // translated [31:0]
  output logic [OUT_DATA_W-1:0] m_tdata,
  // ok [0]
  output logic [OUT_USER_W-1:0] m_tuser
);

  cmd_t    cmd;
  status_t status;

  // controller
  tlpt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath
  tlpt_datapath #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

/* rtl/core/tlpt_ctrl.sv */
// controller state machine of the two-level page table engine
module tlpt_ctrl
  import tlpt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  // state register, directory clear runs first after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.dir_clear_wr = 1'b1;
        cmd.cnt_inc      = 1'b1;
        if (status.cnt_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready   = 1'b1;
        cmd.dir_rd = 1'b1;
        if (s_tvalid) begin
          cmd.load_req = 1'b1;
          state_next   = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd.slot_ld = 1'b1;
        priority if (status.op == OP_MAP) begin
          if (status.dir_present) begin
            cmd.dir_merge_wr = 1'b1;
            state_next       = ST_LEAF_WR;
          end else if (status.pool_full) begin
            cmd.res_kind = RES_FAIL;
            state_next   = ST_DONE;
          end else begin
            cmd.dir_alloc_wr = 1'b1;
            cmd.cnt_clr      = 1'b1;
            state_next       = ST_ZERO;
          end
        end else if (status.op == OP_UNMAP) begin
          if (status.dir_present) begin
            state_next = ST_LEAF_WR;
          end else begin
            cmd.res_kind = RES_FAIL;
            state_next   = ST_DONE;
          end
        end else if (status.op == OP_XLATE) begin
          if (status.dir_present) begin
            state_next = ST_LEAF_CHK;
          end else begin
            cmd.res_kind = RES_FAIL;
            state_next   = ST_DONE;
          end
        end else begin
          cmd.res_kind = RES_FAIL;
          state_next   = ST_DONE;
        end
      end
      ST_ZERO: begin
        cmd.pool_zero_wr = 1'b1;
        cmd.cnt_inc      = 1'b1;
        if (status.cnt_last) begin
          state_next = ST_LEAF_WR;
        end
      end
      ST_LEAF_WR: begin
        cmd.pool_leaf_wr = 1'b1;
        cmd.res_kind     = RES_PASS;
        state_next       = ST_DONE;
      end
      ST_LEAF_CHK: begin
        cmd.res_kind = RES_LEAF;
        state_next   = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

/* rtl/core/tlpt_datapath.sv */
// datapath of the page table engine: directory, table pool, counters, output register
module tlpt_datapath
  import tlpt_pkg::*;
#(
  parameter int TABLE_SLOTS = DEF_TABLE_SLOTS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output status_t               status,
  // virt_addr [31:0], phys_addr [63:32], entry_flags [75:64], zero [79:76]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // operation [1:0]
  input  logic [IN_USER_W-1:0]  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // translated [31:0]
  output logic [OUT_DATA_W-1:0] m_tdata,
  // ok [0]
  output logic [OUT_USER_W-1:0] m_tuser
);

  localparam int SLOT_W     = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int USED_W     = $clog2(TABLE_SLOTS + 1);
  localparam int DIR_W      = 3 + SLOT_W;
  localparam int POOL_DEPTH = TABLE_SLOTS * ENTRIES_PER_TABLE;
  localparam int POOL_AW    = $clog2(POOL_DEPTH);

  // request registers
  logic [1:0]  req_op;
  logic [31:0] req_va;
  logic [19:0] req_frame;
  logic [11:0] req_flags;

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_op    <= s_tuser[1:0];
      req_va    <= s_tdata[31:0];
      req_frame <= s_tdata[63:44];
      req_flags <= s_tdata[75:64];
    end
  end

  // sweep counter for directory clear and table zeroing
  logic [SWEEP_W-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.cnt_clr) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + SWEEP_W'(1);
    end
  end

  // count of pool tables handed out
  logic [USED_W-1:0] used;
  logic              pool_full;
  logic [SLOT_W-1:0] alloc_slot;

  assign pool_full  = (used >= USED_W'(TABLE_SLOTS));
  assign alloc_slot = used[SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (cmd.dir_alloc_wr) begin
      used <= used + USED_W'(1);
    end
  end

  // directory memory
  logic [DIR_W-1:0]     dir_mem [DIR_COUNT];
  logic [DIR_W-1:0]     dir_q;
  logic [DIR_W-1:0]     dir_wdata;
  logic [DIR_IDX_W-1:0] dir_waddr;
  logic                 dir_we;
  logic [SLOT_W-1:0]    dir_slot;

  assign dir_we    = cmd.dir_clear_wr | cmd.dir_alloc_wr | cmd.dir_merge_wr;
  assign dir_waddr = cmd.dir_clear_wr ? cnt[DIR_IDX_W-1:0] : req_va[31:22];
  assign dir_slot  = dir_q[DIR_W-1:3];

  always_comb begin
    priority if (cmd.dir_clear_wr) begin
      dir_wdata = {{SLOT_W{1'b0}}, DIR_WRITABLE};
    end else if (cmd.dir_alloc_wr) begin
      dir_wdata = {alloc_slot, DIR_PRESENT | DIR_WRITABLE | (req_flags[2:0] & DIR_USER)};
    end else begin
      dir_wdata = dir_q | {{SLOT_W{1'b0}}, req_flags[2:0] & (DIR_WRITABLE | DIR_USER)};
    end
  end

  always_ff @(posedge clk) begin
    if (dir_we) begin
      dir_mem[dir_waddr] <= dir_wdata;
    end
    if (cmd.dir_rd) begin
      dir_q <= dir_mem[s_tdata[31:22]];
    end
  end

  // slot of the table that the leaf write and the table zeroing use
  logic [SLOT_W-1:0] slot;

  always_ff @(posedge clk) begin
    if (cmd.slot_ld) begin
      slot <= cmd.dir_alloc_wr ? alloc_slot : dir_slot;
    end
  end

  // table pool memory
  logic [31:0]               pool_mem [POOL_DEPTH];
  logic [31:0]               pool_q;
  logic [31:0]               pool_wdata;
  logic [SLOT_W+TBL_IDX_W-1:0] pool_wfull;
  logic [SLOT_W+TBL_IDX_W-1:0] pool_rfull;
  logic [POOL_AW-1:0]        pool_waddr;
  logic [POOL_AW-1:0]        pool_raddr;
  logic                      pool_we;

  assign pool_we    = cmd.pool_zero_wr | cmd.pool_leaf_wr;
  assign pool_wfull = cmd.pool_zero_wr ? {slot, cnt[TBL_IDX_W-1:0]} : {slot, req_va[21:12]};
  assign pool_rfull = {dir_slot, req_va[21:12]};
  assign pool_waddr = pool_wfull[POOL_AW-1:0];
  assign pool_raddr = pool_rfull[POOL_AW-1:0];

  // leaf for map is frame, present and all flag bits; unmap clears it
  always_comb begin
    if (cmd.pool_leaf_wr && (req_op == OP_MAP)) begin
      pool_wdata = {req_frame, req_flags | FLAG_PRESENT};
    end else begin
      pool_wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (pool_we) begin
      pool_mem[pool_waddr] <= pool_wdata;
    end
    pool_q <= pool_mem[pool_raddr];
  end

  // result registers
  logic        res_ok;
  logic [31:0] res_val;

  always_ff @(posedge clk) begin
    unique case (cmd.res_kind)
      RES_HOLD: begin
      end
      RES_FAIL: begin
        res_ok  <= 1'b0;
        res_val <= '0;
      end
      RES_PASS: begin
        res_ok  <= 1'b1;
        res_val <= '0;
      end
      RES_LEAF: begin
        res_ok  <= pool_q[0];
        res_val <= pool_q[0] ? {pool_q[31:12], req_va[11:0]} : 32'd0;
      end
      default: begin
      end
    endcase
  end

  // output register
  logic out_free;

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= res_val;
      m_tuser <= res_ok;
    end
  end

  // status back to the controller
  assign status.op          = req_op;
  assign status.dir_present = dir_q[0];
  assign status.pool_full   = pool_full;
  assign status.cnt_last    = (cnt == SWEEP_W'(DIR_COUNT - 1));
  assign status.out_free    = out_free;

  // checks
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!m_tvalid || m_tready))
    else $error("result loaded over an untaken result");

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= USED_W'(TABLE_SLOTS))
    else $error("table pool count beyond slot count");

  a_alloc_room: assert property (@(posedge clk) disable iff (rst)
    cmd.dir_alloc_wr |-> !pool_full)
    else $error("table allocated from a full pool");

  a_used_stable: assert property (@(posedge clk) disable iff (rst)
    !cmd.dir_alloc_wr |=> $stable(used))
    else $error("table count moved without an allocation");

endmodule
